// ===== hdl/ltwd_pkg.sv =====
// Shared types and constants for the line-to-wire distance block.
package ltwd_pkg;

  // Fraction bits of every fixed-point field
  localparam int FracBits = 16;

  // Width of the squared numerator and of the denominator handed to the root unit
  localparam int XW = 198;
  localparam int YW = 130;

  // Result width and the number of root steps, one per result bit
  localparam int RW = 32;

  // Distance reported for a zero particle direction: 99.0
  localparam logic [RW-1:0] ZeroDist = RW'(99) << FracBits;

  // Depth of the queue between the front and the root unit
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // One input transaction
  typedef struct packed {
    logic signed [31:0] part_x;
    logic signed [31:0] part_y;
    logic signed [31:0] part_z;
    logic signed [31:0] pdir_x;
    logic signed [31:0] pdir_y;
    logic signed [31:0] pdir_z;
    logic signed [31:0] wire_x;
    logic signed [31:0] wire_y;
    logic signed [31:0] wire_z;
    logic signed [31:0] wdir_x;
    logic signed [31:0] wdir_y;
    logic signed [31:0] wdir_z;
  } in_t;

  // Work item: distance is floor(sqrt(x / y))
  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          zero;
    logic          par;
  } wk_t;

endpackage

// ===== hdl/line_to_wire_distance_top.sv =====
// Top level of the line-to-wire closest-approach distance block.
//
// Input channel: a transaction (particle point and direction, wire point and
// direction, all signed Q16.16) is taken at a clock edge with push high and
// full low. Result channel: while empty is low the oldest result (unsigned
// Q16.16 distance, zero-direction and parallel flags) sits on the outputs and
// is taken at an edge with pop high.
// Throughput: one transaction per cycle while full stays low. A transaction passes
// through the front pipeline of dot and cross products, the queue and the root
// unit, which forms one result bit per stage.
// If the receiver stalls, the root pipeline holds, the four-entry queue
// fills, then the front pipeline holds and full rises.
// Reset empties all pipelines and the queue; nothing else needs clearing.
module line_to_wire_distance_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] part_x_i,
  input  logic signed [31:0] part_y_i,
  input  logic signed [31:0] part_z_i,
  input  logic signed [31:0] pdir_x_i,
  input  logic signed [31:0] pdir_y_i,
  input  logic signed [31:0] pdir_z_i,
  input  logic signed [31:0] wire_x_i,
  input  logic signed [31:0] wire_y_i,
  input  logic signed [31:0] wire_z_i,
  input  logic signed [31:0] wdir_x_i,
  input  logic signed [31:0] wdir_y_i,
  input  logic signed [31:0] wdir_z_i,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        distance_o,
  output logic               zero_direction_o,
  output logic               lines_parallel_o
);
  import ltwd_pkg::*;

  in_t  item;
  wk_t  fr_item, q_item;
  logic fr_ready, fr_valid, fr_take;
  logic q_valid, sq_ready, sq_valid;

  assign item = '{part_x: part_x_i, part_y: part_y_i, part_z: part_z_i,
                  pdir_x: pdir_x_i, pdir_y: pdir_y_i, pdir_z: pdir_z_i,
                  wire_x: wire_x_i, wire_y: wire_y_i, wire_z: wire_z_i,
                  wdir_x: wdir_x_i, wdir_y: wdir_y_i, wdir_z: wdir_z_i};

  assign full  = !fr_ready;
  assign empty = !sq_valid;

  ltwd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (fr_ready),
    .in_item_i   (item),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_take),
    .out_item_o  (fr_item)
  );

  ltwd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_take),
    .in_item_i   (fr_item),
    .out_valid_o (q_valid),
    .out_ready_i (sq_ready),
    .out_item_o  (q_item)
  );

  ltwd_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (sq_ready),
    .in_item_i   (q_item),
    .out_valid_o (sq_valid),
    .out_ready_i (pop),
    .distance_o  (distance_o),
    .zero_o      (zero_direction_o),
    .par_o       (lines_parallel_o)
  );

endmodule

// ===== hdl/ltwd_front.sv =====
// Front pipeline: classifies the lines and forms the numerator and denominator.
module ltwd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ltwd_pkg::in_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ltwd_pkg::wk_t out_item_o
);
  import ltwd_pkg::*;

  localparam int NStg = 7;
  localparam int J [3] = '{1, 2, 0};
  localparam int K [3] = '{2, 0, 1};

  // Stage A: point difference, chosen direction for the point-to-line case
  typedef struct packed {
    logic [2:0][32:0] d;
    logic [2:0][31:0] pd;
    logic [2:0][31:0] wd;
    logic [2:0][31:0] e;
    logic             pz;
    logic             wz;
  } sa_t;

  // Stage B: cross product terms and squares of the chosen direction
  typedef struct packed {
    logic [2:0][63:0] n1;
    logic [2:0][63:0] n2;
    logic [2:0][64:0] v1;
    logic [2:0][64:0] v2;
    logic [2:0][63:0] ee;
    logic [2:0][32:0] d;
    logic             pz;
    logic             wz;
  } sb_t;

  // Stage C: cross products as sign and magnitude
  typedef struct packed {
    logic [2:0][63:0] nm;
    logic [2:0]       ns;
    logic [2:0][64:0] vm;
    logic [2:0][32:0] dm;
    logic [2:0]       ds;
    logic [63:0]      ypar;
    logic             nz;
    logic             pz;
    logic             wz;
  } sc_t;

  // Stage D: partial products of d.n, n.n and v.v
  typedef struct packed {
    logic [2:0][64:0] plo;
    logic [2:0][64:0] phi;
    logic [2:0]       sg;
    logic [2:0][63:0] nhh;
    logic [2:0][63:0] nhl;
    logic [2:0][63:0] nll;
    logic [2:0][65:0] vhh;
    logic [2:0][64:0] vhl;
    logic [2:0][63:0] vll;
    logic [63:0]      ypar;
    logic             nz;
    logic             pz;
    logic             wz;
  } sd_t;

  // Stage E: |d.n|, n.n and v.v summed
  typedef struct packed {
    logic [98:0]   sm;
    logic [YW-1:0] ys;
    logic [YW-1:0] xp;
    logic [63:0]   ypar;
    logic          nz;
    logic          pz;
    logic          wz;
  } se_t;

  // Stage F: partial products of (d.n)^2
  typedef struct packed {
    logic [65:0]   q00;
    logic [65:0]   q11;
    logic [65:0]   q22;
    logic [65:0]   q01;
    logic [65:0]   q02;
    logic [65:0]   q12;
    logic [YW-1:0] ys;
    logic [YW-1:0] xp;
    logic [63:0]   ypar;
    logic          nz;
    logic          pz;
    logic          wz;
  } sf_t;

  logic [NStg-1:0] vld_q;
  logic            en;
  sa_t a_d, a_q;
  sb_t b_d, b_q;
  sc_t c_d, c_q;
  sd_t d_d, d_q;
  se_t e_d, e_q;
  sf_t f_d, f_q;
  wk_t g_d, g_q;

  logic [2:0][31:0] ip, ipd, iwp, iwd;
  logic [2:0][64:0] c_nd, c_nn;
  logic [2:0][65:0] c_vd, c_vn;
  logic [2:0][32:0] c_dn;
  logic [2:0][98:0] e_t;
  logic [98:0]      e_sum, e_neg;
  logic [XW-1:0]    g_xs;
  logic             g_par, g_use;

  // Whole pipeline moves together unless the last stage is held
  assign en          = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStg-1];
  assign out_item_o  = g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
      e_q <= e_d;
      f_q <= f_d;
      g_q <= g_d;
    end
  end

  // Stage A
  always_comb begin
    ip  = {in_item_i.part_z, in_item_i.part_y, in_item_i.part_x};
    ipd = {in_item_i.pdir_z, in_item_i.pdir_y, in_item_i.pdir_x};
    iwp = {in_item_i.wire_z, in_item_i.wire_y, in_item_i.wire_x};
    iwd = {in_item_i.wdir_z, in_item_i.wdir_y, in_item_i.wdir_x};
    a_d.pz = (ipd == '0);
    a_d.wz = (iwd == '0);
    a_d.pd = ipd;
    a_d.wd = iwd;
    for (int i = 0; i < 3; i++) begin
      a_d.d[i] = {ip[i][31], ip[i]} - {iwp[i][31], iwp[i]};
      a_d.e[i] = a_d.wz ? ipd[i] : iwd[i];
    end
  end

  // Stage B
  always_comb begin
    b_d.d  = a_q.d;
    b_d.pz = a_q.pz;
    b_d.wz = a_q.wz;
    for (int i = 0; i < 3; i++) begin
      b_d.n1[i] = $signed(a_q.pd[J[i]]) * $signed(a_q.wd[K[i]]);
      b_d.n2[i] = $signed(a_q.pd[K[i]]) * $signed(a_q.wd[J[i]]);
      b_d.v1[i] = $signed(a_q.d[J[i]]) * $signed(a_q.e[K[i]]);
      b_d.v2[i] = $signed(a_q.d[K[i]]) * $signed(a_q.e[J[i]]);
      b_d.ee[i] = $signed(a_q.e[i]) * $signed(a_q.e[i]);
    end
  end

  // Stage C
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nd[i] = {b_q.n1[i][63], b_q.n1[i]} - {b_q.n2[i][63], b_q.n2[i]};
      c_nn[i] = -c_nd[i];
      c_vd[i] = {b_q.v1[i][64], b_q.v1[i]} - {b_q.v2[i][64], b_q.v2[i]};
      c_vn[i] = -c_vd[i];
      c_dn[i] = -b_q.d[i];
      c_d.ns[i] = c_nd[i][64];
      c_d.nm[i] = c_nd[i][64] ? c_nn[i][63:0] : c_nd[i][63:0];
      c_d.vm[i] = c_vd[i][65] ? c_vn[i][64:0] : c_vd[i][64:0];
      c_d.ds[i] = b_q.d[i][32];
      c_d.dm[i] = b_q.d[i][32] ? c_dn[i] : b_q.d[i];
    end
    c_d.nz   = (c_nd == '0);
    c_d.ypar = b_q.ee[0] + b_q.ee[1] + b_q.ee[2];
    c_d.pz   = b_q.pz;
    c_d.wz   = b_q.wz;
  end

  // Stage D
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d.plo[i] = c_q.dm[i] * c_q.nm[i][31:0];
      d_d.phi[i] = c_q.dm[i] * c_q.nm[i][63:32];
      d_d.sg[i]  = c_q.ds[i] ^ c_q.ns[i];
      d_d.nhh[i] = c_q.nm[i][63:32] * c_q.nm[i][63:32];
      d_d.nhl[i] = c_q.nm[i][63:32] * c_q.nm[i][31:0];
      d_d.nll[i] = c_q.nm[i][31:0] * c_q.nm[i][31:0];
      d_d.vhh[i] = c_q.vm[i][64:32] * c_q.vm[i][64:32];
      d_d.vhl[i] = c_q.vm[i][64:32] * c_q.vm[i][31:0];
      d_d.vll[i] = c_q.vm[i][31:0] * c_q.vm[i][31:0];
    end
    d_d.ypar = c_q.ypar;
    d_d.nz   = c_q.nz;
    d_d.pz   = c_q.pz;
    d_d.wz   = c_q.wz;
  end

  // Stage E
  always_comb begin
    e_d.ys = '0;
    e_d.xp = '0;
    for (int i = 0; i < 3; i++) begin
      e_t[i] = (99'(d_q.phi[i]) << 32) + 99'(d_q.plo[i]);
      if (d_q.sg[i]) begin
        e_t[i] = -e_t[i];
      end
      e_d.ys = e_d.ys + (YW'(d_q.nhh[i]) << 64) + (YW'(d_q.nhl[i]) << 33) + YW'(d_q.nll[i]);
      e_d.xp = e_d.xp + (YW'(d_q.vhh[i]) << 64) + (YW'(d_q.vhl[i]) << 33) + YW'(d_q.vll[i]);
    end
    e_sum   = e_t[0] + e_t[1] + e_t[2];
    e_neg   = -e_sum;
    e_d.sm  = e_sum[98] ? e_neg : e_sum;
    e_d.ypar = d_q.ypar;
    e_d.nz   = d_q.nz;
    e_d.pz   = d_q.pz;
    e_d.wz   = d_q.wz;
  end

  // Stage F: square of |d.n| in 33-bit digits
  always_comb begin
    f_d.q00  = e_q.sm[32:0] * e_q.sm[32:0];
    f_d.q11  = e_q.sm[65:33] * e_q.sm[65:33];
    f_d.q22  = e_q.sm[98:66] * e_q.sm[98:66];
    f_d.q01  = e_q.sm[32:0] * e_q.sm[65:33];
    f_d.q02  = e_q.sm[32:0] * e_q.sm[98:66];
    f_d.q12  = e_q.sm[65:33] * e_q.sm[98:66];
    f_d.ys   = e_q.ys;
    f_d.xp   = e_q.xp;
    f_d.ypar = e_q.ypar;
    f_d.nz   = e_q.nz;
    f_d.pz   = e_q.pz;
    f_d.wz   = e_q.wz;
  end

  // Stage G: pick the formula
  always_comb begin
    g_xs = XW'(f_q.q00) + (XW'(f_q.q01) << 34) + (XW'(f_q.q11) << 66)
         + (XW'(f_q.q02) << 67) + (XW'(f_q.q12) << 100) + (XW'(f_q.q22) << 132);
    g_par    = !f_q.wz && f_q.nz;
    g_use    = f_q.wz || g_par;
    g_d.x    = g_use ? XW'(f_q.xp) : g_xs;
    g_d.y    = g_use ? YW'(f_q.ypar) : f_q.ys;
    g_d.zero = f_q.pz;
    g_d.par  = g_par && !f_q.pz;
  end

endmodule

// ===== hdl/ltwd_fifo.sv =====
// Small register queue between the front pipeline and the root unit.
module ltwd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ltwd_pkg::wk_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ltwd_pkg::wk_t out_item_o
);
  import ltwd_pkg::*;

  wk_t            mem_q [QDepth];
  logic [QAw-1:0] wptr_q, rptr_q;
  logic [QAw:0]   cnt_q;
  logic           wr, rd;

  assign in_ready_o  = (cnt_q != (QAw+1)'(QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rptr_q];
  assign wr          = in_valid_i && in_ready_o;
  assign rd          = out_ready_i && out_valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= in_item_i;
    end
  end

endmodule

// ===== hdl/ltwd_sqrt.sv =====
// Pipelined root of a ratio: one result bit per stage, shifts and adds only.
module ltwd_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ltwd_pkg::wk_t           in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ltwd_pkg::RW-1:0] distance_o,
  output logic                    zero_o,
  output logic                    par_o
);
  import ltwd_pkg::*;

  // rem = x - r^2 y, ry = r y
  typedef struct packed {
    logic [XW-1:0] rem;
    logic [XW-1:0] ry;
    logic [YW-1:0] y;
    logic [RW-1:0] r;
    logic          zero;
    logic          par;
  } sq_t;

  sq_t           prv [RW];
  sq_t           stg_d [RW];
  sq_t           stg_q [RW];
  logic [RW-1:0] vld_q;
  logic          en;

  assign en          = !vld_q[RW-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[RW-1];
  assign distance_o  = stg_q[RW-1].zero ? ZeroDist : stg_q[RW-1].r;
  assign zero_o      = stg_q[RW-1].zero;
  assign par_o       = stg_q[RW-1].par;

  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam int B = RW - 1 - k;
    logic [XW-1:0] dl;
    logic          take;

    if (k == 0) begin : g_first
      assign prv[k] = '{rem: in_item_i.x, ry: '0, y: in_item_i.y, r: '0,
                        zero: in_item_i.zero, par: in_item_i.par};
    end else begin : g_next
      assign prv[k] = stg_q[k-1];
    end

    // Try bit B: (r + 2^B)^2 y - r^2 y = 2^(B+1) r y + 2^(2B) y
    always_comb begin
      dl         = (prv[k].ry << (B + 1)) + (XW'(prv[k].y) << (2 * B));
      take       = (dl <= prv[k].rem);
      stg_d[k]   = prv[k];
      if (take) begin
        stg_d[k].rem  = prv[k].rem - dl;
        stg_d[k].ry   = prv[k].ry + (XW'(prv[k].y) << B);
        stg_d[k].r[B] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[RW-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q <= stg_d;
    end
  end

endmodule

// ===== dv/tb_line_to_wire_distance_top.sv =====
// Self-checking testbench for the line-to-wire closest-approach distance block.
module tb_line_to_wire_distance_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ltwd_pkg::*;

  typedef struct {
    logic [31:0] distance;
    logic        zero_direction;
    logic        lines_parallel;
  } dist_res_t;

  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_t  item = '0;
  logic [31:0] distance_o;
  logic        zero_direction_o, lines_parallel_o;

  dist_res_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  bit quiet_tail = 1'b0;

  line_to_wire_distance_top DUT (
    .clk_i, .rst_ni, .push, .full,
    .part_x_i(item.part_x), .part_y_i(item.part_y), .part_z_i(item.part_z),
    .pdir_x_i(item.pdir_x), .pdir_y_i(item.pdir_y), .pdir_z_i(item.pdir_z),
    .wire_x_i(item.wire_x), .wire_y_i(item.wire_y), .wire_z_i(item.wire_z),
    .wdir_x_i(item.wdir_x), .wdir_y_i(item.wdir_y), .wdir_z_i(item.wdir_z),
    .empty, .pop, .distance_o, .zero_direction_o, .lines_parallel_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [255:0] widen(logic signed [31:0] v);
    return 256'(v);
  endfunction

  function automatic logic signed [255:0] cross_term(logic signed [255:0] a1,
      logic signed [255:0] b2, logic signed [255:0] a2, logic signed [255:0] b1);
    return a1 * b2 - a2 * b1;
  endfunction

  // Exact integer distance: floor(sqrt(num / den)) limited to 32 bits
  function automatic dist_res_t predict_distance(in_t it);
    logic signed [255:0] pd[3], wd[3], d[3], v[3], n[3], s, num, den;
    logic [255:0] c, r;
    dist_res_t res;
    pd[0] = widen(it.pdir_x); pd[1] = widen(it.pdir_y); pd[2] = widen(it.pdir_z);
    wd[0] = widen(it.wdir_x); wd[1] = widen(it.wdir_y); wd[2] = widen(it.wdir_z);
    d[0] = widen(it.part_x) - widen(it.wire_x);
    d[1] = widen(it.part_y) - widen(it.wire_y);
    d[2] = widen(it.part_z) - widen(it.wire_z);
    res.zero_direction = 1'b0;
    res.lines_parallel = 1'b0;
    if (it.pdir_x == 0 && it.pdir_y == 0 && it.pdir_z == 0) begin
      res.distance = ZeroDist;
      res.zero_direction = 1'b1;
      return res;
    end
    if (it.wdir_x == 0 && it.wdir_y == 0 && it.wdir_z == 0) begin
      // degenerate wire: distance of the wire point from the particle line
      v[0] = cross_term(d[1], pd[2], d[2], pd[1]);
      v[1] = cross_term(d[2], pd[0], d[0], pd[2]);
      v[2] = cross_term(d[0], pd[1], d[1], pd[0]);
      num = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      den = pd[0] * pd[0] + pd[1] * pd[1] + pd[2] * pd[2];
    end else begin
      n[0] = cross_term(pd[1], wd[2], pd[2], wd[1]);
      n[1] = cross_term(pd[2], wd[0], pd[0], wd[2]);
      n[2] = cross_term(pd[0], wd[1], pd[1], wd[0]);
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
        // parallel or antiparallel: point-to-line
        v[0] = cross_term(d[1], wd[2], d[2], wd[1]);
        v[1] = cross_term(d[2], wd[0], d[0], wd[2]);
        v[2] = cross_term(d[0], wd[1], d[1], wd[0]);
        num = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        den = wd[0] * wd[0] + wd[1] * wd[1] + wd[2] * wd[2];
        res.lines_parallel = 1'b1;
      end else begin
        s = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        num = s * s;
        den = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      end
    end
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if ((c * c) * $unsigned(den) <= $unsigned(num)) r = c;
    end
    res.distance = r[31:0];
    return res;
  endfunction

  // Random idle burst, none in the quiet tail
  task automatic idle_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Send one transaction and log its expected result at acceptance
  task automatic send_item(in_t it);
    item <= it;
    push <= 1'b1;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
    expected_q.push_back(predict_distance(it));
    items_sent++;
    idle_gap();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // Receiver: random stalls in bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      pop <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!quiet_tail) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    dist_res_t exp_r;
    if (pop && !empty) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: distance %h", distance_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (distance_o !== exp_r.distance || zero_direction_o !== exp_r.zero_direction ||
            lines_parallel_o !== exp_r.lines_parallel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected %h/%b/%b, got %h/%b/%b", results_seen,
                     exp_r.distance, exp_r.zero_direction, exp_r.lines_parallel,
                     distance_o, zero_direction_o, lines_parallel_o);
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_field(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 16)) - 8;
      2: return ($signed($urandom_range(0, 64)) - 32) <<< FracBits;
      default: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endcase
  endfunction

  function automatic in_t random_item(int mode);
    in_t it;
    it.part_x = pick_field(mode); it.part_y = pick_field(mode); it.part_z = pick_field(mode);
    it.pdir_x = pick_field(mode); it.pdir_y = pick_field(mode); it.pdir_z = pick_field(mode);
    it.wire_x = pick_field(mode); it.wire_y = pick_field(mode); it.wire_z = pick_field(mode);
    it.wdir_x = pick_field(mode); it.wdir_y = pick_field(mode); it.wdir_z = pick_field(mode);
    return it;
  endfunction

  // Directed corners: degenerate directions, parallels, extremes, saturation
  task automatic test_directed();
    in_t it;
    it = '0; send_item(it);
    it = random_item(0); it.pdir_x = 0; it.pdir_y = 0; it.pdir_z = 0; send_item(it);
    it = random_item(2); it.wdir_x = 0; it.wdir_y = 0; it.wdir_z = 0; send_item(it);
    it = random_item(0); it.wdir_x = 0; it.wdir_y = 0; it.wdir_z = 0; send_item(it);
    it = random_item(2); it.wdir_x = it.pdir_x * 2; it.wdir_y = it.pdir_y * 2;
    it.wdir_z = it.pdir_z * 2; send_item(it);
    it = random_item(1); it.wdir_x = -it.pdir_x; it.wdir_y = -it.pdir_y;
    it.wdir_z = -it.pdir_z; send_item(it);
    it = '0; it.pdir_x = 32'sh1_0000; it.wdir_y = 32'sh1_0000; it.part_z = 32'sh3_0000;
    send_item(it);
    it = '0; it.pdir_x = 32'sh1_0000; it.wdir_y = 32'sh1_0000;
    it.part_z = 32'sh7FFF_FFFF; it.wire_z = 32'sh8000_0000; send_item(it);
    it = '0; it.pdir_x = 32'sh1_0000; it.wdir_x = 32'sh1_0000;
    it.part_y = 32'sh7FFF_FFFF; it.wire_y = 32'sh8000_0000; send_item(it);
    it = '1; send_item(it);
    it = {12{32'sh8000_0000}}; send_item(it);
    it = {12{32'sh7FFF_FFFF}}; send_item(it);
    for (int k = 0; k < 8; k++) send_item(random_item(3));
  endtask

  // Random mix; parallel and degenerate shapes built on purpose
  task automatic test_random(int count);
    in_t it;
    int sel, k;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      it = random_item(sel < 4 ? 0 : (sel < 6 ? 1 : (sel < 8 ? 2 : 3)));
      case ($urandom_range(0, 7))
        0: begin
          k = $urandom_range(0, 1) ? $urandom_range(1, 3) : -$signed($urandom_range(1, 3));
          it.pdir_x = it.pdir_x >>> 4; it.pdir_y = it.pdir_y >>> 4; it.pdir_z = it.pdir_z >>> 4;
          it.wdir_x = it.pdir_x * k; it.wdir_y = it.pdir_y * k; it.wdir_z = it.pdir_z * k;
        end
        1: begin it.pdir_x = 0; it.pdir_y = 0; it.pdir_z = 0; end
        2: begin it.wdir_x = 0; it.wdir_y = 0; it.wdir_z = 0; end
        default: ;
      endcase
      send_item(it);
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(550);
    quiet_tail = 1'b1;
    test_random(130);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d transactions (corners, parallel and degenerate lines, random), checked %0d",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
